// File: rtl/brd_pkg.sv
// Shared types and constants for the Bayer replication demosaic.
`timescale 1ns / 1ps

package brd_pkg;

    // Line store geometry
    localparam int MAX_WIDTH = 4096;
    localparam int COL_W     = $clog2(MAX_WIDTH);
    localparam int IMG_W_W   = 13;
    localparam int IMG_H_W   = 16;

    // Word fields
    localparam int SAMPLE_W = 16;
    localparam int BYTE_W   = 8;
    localparam int ORDER_W  = 2;
    localparam int BITS_W   = 5;

    // Configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;
    localparam logic [CFG_IDX_W-1:0] REG_MOSAIC_ORDER = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SAMPLE_BITS  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 2'd3;

    localparam logic [BITS_W-1:0] BYTE_BITS = 5'd8;

    // Queue between front and back
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

    // One classified sample on its way to the back end
    typedef struct packed {
        logic [SAMPLE_W-1:0] sample;
        logic [SAMPLE_W-1:0] above;
        logic                x_odd;
        logic                x_zero;
        logic                y_odd;
        logic                y_zero;
        logic                last;
    } t_item;

endpackage

// File: rtl/brd_front.sv
// Front end: raster counters, previous-row line store and sample classification.
`timescale 1ns / 1ps

module brd_front (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    output logic                                o_ready,
    input  logic [brd_pkg::SAMPLE_W-1:0]        i_raw_sample,
    input  logic [brd_pkg::IMG_W_W-1:0]         i_image_width,
    input  logic [brd_pkg::IMG_H_W-1:0]         i_image_height,
    input  logic                                i_full,
    output logic                                o_push,
    output brd_pkg::t_item                      o_item
);

    logic [brd_pkg::SAMPLE_W-1:0] r_line [brd_pkg::MAX_WIDTH];
    logic [brd_pkg::SAMPLE_W-1:0] r_above;
    logic [brd_pkg::COL_W-1:0]    r_col, n_col;
    logic [brd_pkg::IMG_H_W-1:0]  r_row, n_row;
    logic                         r_f_valid;
    brd_pkg::t_item               r_f_item, n_f_item;

    logic                         accept;
    logic [brd_pkg::IMG_W_W-1:0]  w_eff;
    logic [brd_pkg::IMG_H_W-1:0]  h_eff;
    logic [brd_pkg::IMG_W_W-1:0]  col_inc;
    logic [brd_pkg::IMG_H_W:0]    row_inc;
    logic                         row_end;
    logic                         frame_end;

    assign o_push  = r_f_valid && !i_full;
    assign o_ready = !r_f_valid || !i_full;
    assign accept  = i_valid && o_ready;

    // Clamp width to 1..MAX_WIDTH, height zero acts as one
    always_comb begin
        w_eff = i_image_width;
        if (i_image_width == '0) begin
            w_eff = brd_pkg::IMG_W_W'(1);
        end else if (i_image_width > brd_pkg::IMG_W_W'(brd_pkg::MAX_WIDTH)) begin
            w_eff = brd_pkg::IMG_W_W'(brd_pkg::MAX_WIDTH);
        end
        h_eff = (i_image_height == '0) ? brd_pkg::IMG_H_W'(1) : i_image_height;
    end

    assign col_inc   = brd_pkg::IMG_W_W'(r_col) + brd_pkg::IMG_W_W'(1);
    assign row_inc   = {1'b0, r_row} + (brd_pkg::IMG_H_W+1)'(1);
    assign row_end   = col_inc >= w_eff;
    assign frame_end = row_end && (row_inc >= {1'b0, h_eff});

    always_comb begin
        n_col = r_col;
        n_row = r_row;
        if (row_end) begin
            n_col = '0;
            n_row = frame_end ? '0 : row_inc[brd_pkg::IMG_H_W-1:0];
        end else begin
            n_col = col_inc[brd_pkg::COL_W-1:0];
        end
    end

    always_comb begin
        n_f_item        = r_f_item;
        n_f_item.sample = i_raw_sample;
        n_f_item.above  = '0;
        n_f_item.x_odd  = r_col[0];
        n_f_item.x_zero = (r_col == '0);
        n_f_item.y_odd  = r_row[0];
        n_f_item.y_zero = (r_row == '0);
        n_f_item.last   = frame_end;
    end

    // Read old entry and write the new sample at the same column
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_above      <= r_line[r_col];
            r_line[r_col] <= i_raw_sample;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_f_item <= n_f_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col     <= '0;
            r_row     <= '0;
            r_f_valid <= 1'b0;
        end else begin
            if (accept) begin
                r_col <= n_col;
                r_row <= n_row;
            end
            if (accept) begin
                r_f_valid <= 1'b1;
            end else if (o_push) begin
                r_f_valid <= 1'b0;
            end
        end
    end

    always_comb begin
        o_item       = r_f_item;
        o_item.above = r_above;
    end

endmodule

// File: rtl/brd_fifo.sv
// Short word queue between the front and back ends.
`timescale 1ns / 1ps

module brd_fifo (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  brd_pkg::t_item i_item,
    output logic           o_full,
    input  logic           i_pop,
    output logic           o_empty,
    output brd_pkg::t_item o_item
);

    brd_pkg::t_item                r_mem [brd_pkg::FIFO_DEPTH];
    logic [brd_pkg::FIFO_AW-1:0]   r_wr_ptr;
    logic [brd_pkg::FIFO_AW-1:0]   r_rd_ptr;
    logic [brd_pkg::FIFO_AW:0]     r_count;

    assign o_full  = (r_count == (brd_pkg::FIFO_AW+1)'(brd_pkg::FIFO_DEPTH));
    assign o_empty = (r_count == '0);
    assign o_item  = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + brd_pkg::FIFO_AW'(1);
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + brd_pkg::FIFO_AW'(1);
            end
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + (brd_pkg::FIFO_AW+1)'(1);
                2'b01:   r_count <= r_count - (brd_pkg::FIFO_AW+1)'(1);
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

// File: rtl/brd_back.sv
// Back end: neighbor holds, channel replication, scaling and output register.
`timescale 1ns / 1ps

module brd_back (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_empty,
    input  brd_pkg::t_item                i_item,
    output logic                          o_pop,
    input  logic [brd_pkg::ORDER_W-1:0]   i_mosaic_order,
    input  logic [brd_pkg::BITS_W-1:0]    i_sample_bits,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic [brd_pkg::BYTE_W-1:0]    o_out_byte0,
    output logic [brd_pkg::BYTE_W-1:0]    o_out_byte1,
    output logic [brd_pkg::BYTE_W-1:0]    o_out_byte2,
    output logic                          o_frame_last
);

    logic [brd_pkg::SAMPLE_W-1:0] r_cur_even, r_cur_odd, r_abv_even, r_abv_odd;
    logic                         r_valid;
    logic [brd_pkg::BYTE_W-1:0]   r_b0, r_b1, r_b2;
    logic                         r_last;

    logic [brd_pkg::SAMPLE_W-1:0] cur_e, cur_o, abv_e, abv_o;
    logic [brd_pkg::SAMPLE_W-1:0] green, chan_a, chan_b, v0, v2;
    logic [brd_pkg::BITS_W-1:0]   shift;
    logic [brd_pkg::SAMPLE_W-1:0] s0, s1, s2;

    assign o_pop = !i_empty && (!r_valid || i_ready);

    always_comb begin
        if (i_item.x_odd) begin
            cur_o = i_item.sample;
            cur_e = r_cur_even;
            abv_o = i_item.above;
            abv_e = r_abv_even;
        end else begin
            cur_e = i_item.sample;
            cur_o = i_item.x_zero ? '0 : r_cur_odd;
            abv_e = i_item.above;
            abv_o = i_item.x_zero ? '0 : r_abv_odd;
        end
        // No row above on the first row
        if (i_item.y_zero) begin
            abv_e = '0;
            abv_o = '0;
        end

        if (!i_mosaic_order[1]) begin
            green  = i_item.y_odd ? cur_e : cur_o;
            chan_b = i_item.y_odd ? abv_e : cur_e;
            chan_a = i_item.y_odd ? cur_o : abv_o;
        end else begin
            green  = i_item.y_odd ? cur_o : cur_e;
            chan_b = i_item.y_odd ? cur_e : abv_e;
            chan_a = i_item.y_odd ? abv_o : cur_o;
        end

        v0 = i_mosaic_order[0] ? chan_b : chan_a;
        v2 = i_mosaic_order[0] ? chan_a : chan_b;

        shift = (i_sample_bits < brd_pkg::BYTE_BITS) ? '0
                                                      : (i_sample_bits - brd_pkg::BYTE_BITS);
        s0 = v0 >> shift;
        s1 = green >> shift;
        s2 = v2 >> shift;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cur_even <= '0;
            r_cur_odd  <= '0;
            r_abv_even <= '0;
            r_abv_odd  <= '0;
        end else if (o_pop) begin
            if (i_item.x_odd) begin
                r_cur_odd <= i_item.sample;
                r_abv_odd <= i_item.above;
            end else begin
                r_cur_even <= i_item.sample;
                r_abv_even <= i_item.above;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_b0   <= s0[brd_pkg::BYTE_W-1:0];
            r_b1   <= s1[brd_pkg::BYTE_W-1:0];
            r_b2   <= s2[brd_pkg::BYTE_W-1:0];
            r_last <= i_item.last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_pop) begin
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    assign o_valid      = r_valid;
    assign o_out_byte0  = r_b0;
    assign o_out_byte1  = r_b1;
    assign o_out_byte2  = r_b2;
    assign o_frame_last = r_last;

endmodule

// File: rtl/bayer_replication_demosaic.sv
// Top level of the Bayer demosaic with nearest-neighbor replication.
// Takes one raw sample per cycle in raster order and returns one packed pixel
// per sample at a sustained rate of one word per cycle while the output is not
// stalled. The accepting edge loads the front register with the line store read,
// the word is then pushed into the queue, and its pop sets output valid with the
// output register. The front end reads and rewrites the previous-row line store
// (one read and one write port, 4096 x 16) for each sample, and a four-entry
// queue lets the back end stall on output backpressure without losing words.
// Configuration registers may be written only while the block is idle.
`timescale 1ns / 1ps

module bayer_replication_demosaic (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    output logic                                o_ready,
    input  logic [brd_pkg::SAMPLE_W-1:0]        i_raw_sample,
    output logic                                o_valid,
    input  logic                                i_ready,
    output logic [brd_pkg::BYTE_W-1:0]          o_out_byte0,
    output logic [brd_pkg::BYTE_W-1:0]          o_out_byte1,
    output logic [brd_pkg::BYTE_W-1:0]          o_out_byte2,
    output logic                                o_frame_last,
    input  logic                                i_cfg_we,
    input  logic [brd_pkg::CFG_IDX_W-1:0]       i_cfg_idx,
    input  logic [brd_pkg::CFG_DATA_W-1:0]      i_cfg_data
);

    logic [brd_pkg::ORDER_W-1:0] r_mosaic_order;
    logic [brd_pkg::BITS_W-1:0]  r_sample_bits;
    logic [brd_pkg::IMG_W_W-1:0] r_image_width;
    logic [brd_pkg::IMG_H_W-1:0] r_image_height;

    logic           push, full, pop, empty;
    brd_pkg::t_item front_item, back_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mosaic_order <= '0;
            r_sample_bits  <= brd_pkg::BITS_W'(8);
            r_image_width  <= brd_pkg::IMG_W_W'(640);
            r_image_height <= brd_pkg::IMG_H_W'(480);
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                brd_pkg::REG_MOSAIC_ORDER:
                    r_mosaic_order <= i_cfg_data[brd_pkg::ORDER_W-1:0];
                brd_pkg::REG_SAMPLE_BITS:
                    r_sample_bits <= i_cfg_data[brd_pkg::BITS_W-1:0];
                brd_pkg::REG_IMAGE_WIDTH:
                    r_image_width <= i_cfg_data[brd_pkg::IMG_W_W-1:0];
                brd_pkg::REG_IMAGE_HEIGHT:
                    r_image_height <= i_cfg_data[brd_pkg::IMG_H_W-1:0];
                default: begin
                end
            endcase
        end
    end

    brd_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_raw_sample   (i_raw_sample),
        .i_image_width  (r_image_width),
        .i_image_height (r_image_height),
        .i_full         (full),
        .o_push         (push),
        .o_item         (front_item)
    );

    brd_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_item  (front_item),
        .o_full  (full),
        .i_pop   (pop),
        .o_empty (empty),
        .o_item  (back_item)
    );

    brd_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_empty        (empty),
        .i_item         (back_item),
        .o_pop          (pop),
        .i_mosaic_order (r_mosaic_order),
        .i_sample_bits  (r_sample_bits),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_out_byte0    (o_out_byte0),
        .o_out_byte1    (o_out_byte1),
        .o_out_byte2    (o_out_byte2),
        .o_frame_last   (o_frame_last)
    );

endmodule

// File: tb/bayer_replication_demosaic_tb.sv
// Self-checking testbench for the Bayer replication demosaic top level.
`timescale 1ns / 1ps

module bayer_replication_demosaic_tb;

    localparam int HALF_PERIOD     = 10;
    localparam int RESET_CYCLES    = 8;
    localparam int DRAIN_CYCLES    = 8;
    localparam int HOLD_OFF_CYCLES = 120;
    localparam int RANDOM_SAMPLES  = 400;
    localparam int WIDE_ROW        = 256;
    localparam int CYCLE_LIMIT     = 2_000_000;
    localparam int MAX_REPORTS     = 100;

    // Phase layout (odd-odd or odd-even site for channel A) and which channel leads
    typedef enum logic [brd_pkg::ORDER_W-1:0] {
        ORDER_OO_A_FIRST = 2'd0,
        ORDER_OO_B_FIRST = 2'd1,
        ORDER_OE_A_FIRST = 2'd2,
        ORDER_OE_B_FIRST = 2'd3
    } t_mosaic_order;

    typedef struct {
        logic [brd_pkg::BYTE_W-1:0] byte0;
        logic [brd_pkg::BYTE_W-1:0] byte1;
        logic [brd_pkg::BYTE_W-1:0] byte2;
        logic                       last;
    } t_pixel;

    logic                           i_clk        = 1'b0;
    logic                           i_rst_n      = 1'b0;
    logic                           i_valid      = 1'b0;
    logic                           o_ready;
    logic [brd_pkg::SAMPLE_W-1:0]   i_raw_sample = '0;
    logic                           o_valid;
    logic                           i_ready      = 1'b0;
    logic [brd_pkg::BYTE_W-1:0]     o_out_byte0;
    logic [brd_pkg::BYTE_W-1:0]     o_out_byte1;
    logic [brd_pkg::BYTE_W-1:0]     o_out_byte2;
    logic                           o_frame_last;
    logic                           i_cfg_we     = 1'b0;
    logic [brd_pkg::CFG_IDX_W-1:0]  i_cfg_idx    = '0;
    logic [brd_pkg::CFG_DATA_W-1:0] i_cfg_data   = '0;

    // Shadow of the block's registers and pixel state
    t_mosaic_order                cur_order;
    logic [brd_pkg::BITS_W-1:0]   cur_bits;
    logic [brd_pkg::IMG_W_W-1:0]  cur_width;
    logic [brd_pkg::IMG_H_W-1:0]  cur_height;
    logic [brd_pkg::SAMPLE_W-1:0] row_above [brd_pkg::MAX_WIDTH];
    int                           col_pos;
    int                           row_pos;
    logic [brd_pkg::SAMPLE_W-1:0] even_here;
    logic [brd_pkg::SAMPLE_W-1:0] odd_here;
    logic [brd_pkg::SAMPLE_W-1:0] even_above;
    logic [brd_pkg::SAMPLE_W-1:0] odd_above;

    t_pixel pending_pixels [$];
    int     mismatches    = 0;
    int     words_checked = 0;
    int     cycle_count   = 0;
    bit     sender_calm   = 1'b0;
    bit     hold_off_req  = 1'b0;

    bayer_replication_demosaic uut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_ready      (o_ready),
        .i_raw_sample (i_raw_sample),
        .o_valid      (o_valid),
        .i_ready      (i_ready),
        .o_out_byte0  (o_out_byte0),
        .o_out_byte1  (o_out_byte1),
        .o_out_byte2  (o_out_byte2),
        .o_frame_last (o_frame_last),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_data   (i_cfg_data)
    );

    always #HALF_PERIOD i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
    end

    initial begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("bayer_replication_demosaic_tb failed");
        $finish;
    end

    function automatic void reset_shadow();
        cur_order  = ORDER_OO_A_FIRST;
        cur_bits   = brd_pkg::BYTE_BITS;
        cur_width  = 13'd640;
        cur_height = 16'd480;
        for (int k = 0; k < brd_pkg::MAX_WIDTH; k++) row_above[k] = '0;
        col_pos    = 0;
        row_pos    = 0;
        even_here  = '0;
        odd_here   = '0;
        even_above = '0;
        odd_above  = '0;
    endfunction

    function automatic int active_width();
        if (cur_width == 0) return 1;
        if (cur_width > brd_pkg::MAX_WIDTH) return brd_pkg::MAX_WIDTH;
        return cur_width;
    endfunction

    function automatic int active_height();
        if (cur_height == 0) return 1;
        return cur_height;
    endfunction

    function automatic logic [brd_pkg::BYTE_W-1:0] to_byte(
        input logic [brd_pkg::SAMPLE_W-1:0] v);
        logic [31:0] wide;
        wide = v;
        if (cur_bits > brd_pkg::BYTE_BITS) wide = wide >> (cur_bits - brd_pkg::BYTE_BITS);
        return wide[brd_pkg::BYTE_W-1:0];
    endfunction

    // Nearest-site replication for one sample; advances the shadow state
    function automatic t_pixel replicate_pixel(input logic [brd_pkg::SAMPLE_W-1:0] s);
        t_pixel                       px;
        bit                           x_odd;
        bit                           y_odd;
        logic [brd_pkg::SAMPLE_W-1:0] old;
        logic [brd_pkg::SAMPLE_W-1:0] c_even;
        logic [brd_pkg::SAMPLE_W-1:0] c_odd;
        logic [brd_pkg::SAMPLE_W-1:0] a_even;
        logic [brd_pkg::SAMPLE_W-1:0] a_odd;
        logic [brd_pkg::SAMPLE_W-1:0] green;
        logic [brd_pkg::SAMPLE_W-1:0] chan_a;
        logic [brd_pkg::SAMPLE_W-1:0] chan_b;
        x_odd = col_pos[0];
        y_odd = row_pos[0];
        old   = row_above[col_pos];
        if (x_odd) begin
            c_odd  = s;
            c_even = even_here;
            a_odd  = old;
            a_even = even_above;
        end else begin
            c_even = s;
            c_odd  = (col_pos > 0) ? odd_here : '0;
            a_even = old;
            a_odd  = (col_pos > 0) ? odd_above : '0;
        end
        // nothing above the first row
        if (row_pos == 0) begin
            a_even = '0;
            a_odd  = '0;
        end
        if (cur_order == ORDER_OO_A_FIRST || cur_order == ORDER_OO_B_FIRST) begin
            green  = y_odd ? c_even : c_odd;
            chan_b = y_odd ? a_even : c_even;
            chan_a = y_odd ? c_odd  : a_odd;
        end else begin
            green  = y_odd ? c_odd  : c_even;
            chan_b = y_odd ? c_even : a_even;
            chan_a = y_odd ? a_odd  : c_odd;
        end
        if (cur_order == ORDER_OO_A_FIRST || cur_order == ORDER_OE_A_FIRST) begin
            px.byte0 = to_byte(chan_a);
            px.byte2 = to_byte(chan_b);
        end else begin
            px.byte0 = to_byte(chan_b);
            px.byte2 = to_byte(chan_a);
        end
        px.byte1 = to_byte(green);

        if (x_odd) begin
            odd_here  = s;
            odd_above = old;
        end else begin
            even_here  = s;
            even_above = old;
        end
        row_above[col_pos] = s;

        // a row or frame ends once the count reaches or passes the size
        px.last = 1'b0;
        if (col_pos + 1 >= active_width()) begin
            col_pos = 0;
            if (row_pos + 1 >= active_height()) begin
                row_pos = 0;
                px.last = 1'b1;
            end else begin
                row_pos = row_pos + 1;
            end
        end else begin
            col_pos = col_pos + 1;
        end
        return px;
    endfunction

    task automatic report_mismatch(input string what,
                                   input logic [brd_pkg::SAMPLE_W-1:0] got,
                                   input logic [brd_pkg::SAMPLE_W-1:0] want);
        if (mismatches < MAX_REPORTS)
            $display("word %0d: %s got %h, expected %h", words_checked, what, got, want);
        mismatches++;
    endtask

    always @(posedge i_clk) begin : word_checker
        t_pixel want;
        if (i_rst_n && i_ready && o_valid !== 1'b0) begin
            if (o_valid !== 1'b1) begin
                report_mismatch("o_valid", o_valid, 1'b1);
            end else if (pending_pixels.size() == 0) begin
                report_mismatch("unexpected word", o_out_byte0, '0);
            end else begin
                want = pending_pixels.pop_front();
                if (o_out_byte0 !== want.byte0) report_mismatch("byte0", o_out_byte0, want.byte0);
                if (o_out_byte1 !== want.byte1) report_mismatch("byte1", o_out_byte1, want.byte1);
                if (o_out_byte2 !== want.byte2) report_mismatch("byte2", o_out_byte2, want.byte2);
                if (o_frame_last !== want.last)
                    report_mismatch("frame_last", o_frame_last, want.last);
            end
            words_checked++;
        end
    end

    // Output side: random stalls, calm stretches, and the requested long hold-off
    initial begin : result_sink
        int hold_left;
        int stretch_left;
        bit stretch_calm;
        hold_left    = 0;
        stretch_left = 0;
        stretch_calm = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_off_req) begin
                hold_off_req = 1'b0;
                hold_left    = HOLD_OFF_CYCLES;
            end
            if (stretch_left == 0) begin
                stretch_left = $urandom_range(300, 30);
                stretch_calm = ($urandom_range(3, 0) == 0);
            end
            stretch_left--;
            if (hold_left > 0) begin
                hold_left--;
                i_ready <= 1'b0;
            end else if (stretch_calm) begin
                i_ready <= 1'b1;
            end else if ($urandom_range(99, 0) < 3) begin
                hold_left = $urandom_range(24, 5);
                i_ready <= 1'b0;
            end else begin
                i_ready <= ($urandom_range(99, 0) >= 25);
            end
        end
    end

    function automatic int sender_gap();
        int r;
        if (sender_calm) return 0;
        r = $urandom_range(99, 0);
        if (r < 55) return 0;
        if (r < 88) return $urandom_range(3, 1);
        if (r < 97) return $urandom_range(10, 4);
        return $urandom_range(24, 11);
    endfunction

    function automatic logic [brd_pkg::SAMPLE_W-1:0] random_sample();
        int r;
        r = $urandom_range(99, 0);
        if (r < 8) return '0;
        if (r < 16) return '1;
        return brd_pkg::SAMPLE_W'($urandom_range(16'hFFFF, 0));
    endfunction

    task automatic send_sample(input logic [brd_pkg::SAMPLE_W-1:0] s);
        int     gap;
        t_pixel px;
        gap = sender_gap();
        @(negedge i_clk);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_valid      <= 1'b1;
        i_raw_sample <= s;
        @(posedge i_clk);
        while (o_ready !== 1'b1) @(posedge i_clk);
        px = replicate_pixel(s);
        pending_pixels.insert(pending_pixels.size(), px);
    endtask

    // Drop valid and let every expected word come out
    task automatic wait_idle();
        @(negedge i_clk);
        i_valid <= 1'b0;
        while (pending_pixels.size() != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [brd_pkg::CFG_IDX_W-1:0] idx,
                             input logic [brd_pkg::CFG_DATA_W-1:0] value);
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= value;
        case (idx)
            brd_pkg::REG_MOSAIC_ORDER:
                cur_order  = t_mosaic_order'(value[brd_pkg::ORDER_W-1:0]);
            brd_pkg::REG_SAMPLE_BITS:  cur_bits   = value[brd_pkg::BITS_W-1:0];
            brd_pkg::REG_IMAGE_WIDTH:  cur_width  = value[brd_pkg::IMG_W_W-1:0];
            brd_pkg::REG_IMAGE_HEIGHT: cur_height = value[brd_pkg::IMG_H_W-1:0];
            default: ;
        endcase
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic test_reset_values();
        send_sample(16'hFFFF);
        send_sample(16'h0000);
        send_sample(16'h8001);
    endtask

    // Shrink width and height while the counters sit beyond them
    task automatic test_midframe_reconfig();
        wait_idle();
        write_reg(brd_pkg::REG_IMAGE_WIDTH, 16'd2);
        write_reg(brd_pkg::REG_IMAGE_HEIGHT, 16'hFFFF);
        send_sample(16'h1234);
        wait_idle();
        write_reg(brd_pkg::REG_IMAGE_HEIGHT, 16'd1);
        send_sample(16'hFEDC);
        send_sample(16'h00FF);
    endtask

    task automatic test_each_order();
        logic [brd_pkg::SAMPLE_W-1:0]   tile [4]     = '{16'hFFFF, 16'h0000, 16'hA5C3,
                                                         16'h5A3C};
        logic [brd_pkg::CFG_DATA_W-1:0] bits_for [4] = '{16'd0, 16'd16, 16'd11, 16'hFFFF};
        wait_idle();
        write_reg(brd_pkg::REG_IMAGE_WIDTH, 16'd2);
        write_reg(brd_pkg::REG_IMAGE_HEIGHT, 16'd2);
        for (int o = 0; o < 4; o++) begin
            wait_idle();
            write_reg(brd_pkg::REG_MOSAIC_ORDER, brd_pkg::CFG_DATA_W'(o));
            write_reg(brd_pkg::REG_SAMPLE_BITS, bits_for[o]);
            for (int k = 0; k < 4; k++) send_sample(tile[(k + o) % 4]);
        end
    endtask

    // Zero width and height act as one: every pixel closes a frame
    task automatic test_degenerate_size();
        wait_idle();
        write_reg(brd_pkg::REG_MOSAIC_ORDER, 16'hFFFE);
        write_reg(brd_pkg::REG_SAMPLE_BITS, 16'hFFE8);
        write_reg(brd_pkg::REG_IMAGE_WIDTH, 16'hE000);
        write_reg(brd_pkg::REG_IMAGE_HEIGHT, 16'h0000);
        send_sample(16'hC0DE);
        send_sample(16'h7FFF);
    endtask

    // Two long rows: the second reads back every entry the first wrote
    task automatic test_wide_rows();
        wait_idle();
        write_reg(brd_pkg::REG_MOSAIC_ORDER, brd_pkg::CFG_DATA_W'($urandom_range(3, 0)));
        write_reg(brd_pkg::REG_SAMPLE_BITS, 16'd12);
        write_reg(brd_pkg::REG_IMAGE_WIDTH, brd_pkg::CFG_DATA_W'(WIDE_ROW));
        write_reg(brd_pkg::REG_IMAGE_HEIGHT, 16'd2);
        hold_off_req = 1'b1;
        for (int k = 0; k < 2 * WIDE_ROW; k++) send_sample(random_sample());
    endtask

    task automatic test_random_frames();
        int                             sent;
        int                             frame_len;
        int                             r;
        logic [brd_pkg::CFG_DATA_W-1:0] word;
        sent = 0;
        while (sent < RANDOM_SAMPLES) begin
            // reconfigure only at frame boundaries, otherwise run back-to-back frames
            if (sent == 0 || $urandom_range(99, 0) < 60) begin
                wait_idle();
                write_reg(brd_pkg::REG_MOSAIC_ORDER,
                          brd_pkg::CFG_DATA_W'($urandom_range(16'hFFFF, 0)));
                word = brd_pkg::CFG_DATA_W'($urandom_range(16'hFFFF, 0));
                word[brd_pkg::BITS_W-1:0] = brd_pkg::BITS_W'(($urandom_range(9, 0) < 7)
                                                             ? $urandom_range(16, 8)
                                                             : $urandom_range(31, 0));
                write_reg(brd_pkg::REG_SAMPLE_BITS, word);
                word = brd_pkg::CFG_DATA_W'($urandom_range(16'hFFFF, 0));
                r = $urandom_range(99, 0);
                if (r < 80)
                    word[brd_pkg::IMG_W_W-1:0] = brd_pkg::IMG_W_W'($urandom_range(12, 1));
                else if (r < 95)
                    word[brd_pkg::IMG_W_W-1:0] = brd_pkg::IMG_W_W'($urandom_range(64, 13));
                else
                    word[brd_pkg::IMG_W_W-1:0] = '0;
                write_reg(brd_pkg::REG_IMAGE_WIDTH, word);
                write_reg(brd_pkg::REG_IMAGE_HEIGHT,
                          brd_pkg::CFG_DATA_W'($urandom_range(6, 0)));
            end
            sender_calm = ($urandom_range(3, 0) == 0);
            frame_len = active_width() * active_height();
            repeat (frame_len) send_sample(random_sample());
            sent += frame_len;
        end
        sender_calm = 1'b0;
    endtask

    initial begin
        reset_shadow();
        repeat (RESET_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_reset_values();
        test_midframe_reconfig();
        test_each_order();
        test_degenerate_size();
        test_wide_rows();
        test_random_frames();

        wait_idle();
        if (mismatches == 0) begin
            $display("bayer_replication_demosaic_tb passed");
        end else begin
            $display("bayer_replication_demosaic_tb failed");
        end
        $finish;
    end

endmodule
